[rtl/render_state_set_interner_defines.svh]
// Assertion macros of the render state set interner RTL.
`ifndef RENDER_STATE_SET_INTERNER_DEFINES_SVH
`define RENDER_STATE_SET_INTERNER_DEFINES_SVH

`ifndef ASSERT_OFF

`define RSI_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

`define RSI_ASSERT_NEXT(lbl, pre, post, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |=> (post)) \
        else $error(msg);

`else

`define RSI_ASSERT(lbl, prop, msg)

`define RSI_ASSERT_NEXT(lbl, pre, post, msg)

`endif

`endif

[rtl/rsi_pkg.sv]
// Types and constants of the render state set interner.
package rsi_pkg;

    localparam int ALPHA_BITS     = 10;
    localparam int CULL_BITS      = 10;
    localparam int FOG_BITS       = 10;
    localparam int MATERIAL_BITS  = 14;
    localparam int WIREFRAME_BITS = 10;
    localparam int ZBUFFER_BITS   = 10;
    localparam int KEY_W          = ALPHA_BITS + CULL_BITS + FOG_BITS + MATERIAL_BITS
                                    + WIREFRAME_BITS + ZBUFFER_BITS;
    localparam int INDEX_W        = 8;

    typedef logic [KEY_W-1:0] t_key;

    typedef enum logic [1:0] {
        ST_FOUND = 2'd0,
        ST_NEW   = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    typedef struct packed {
        logic [INDEX_W-1:0] set_index;
        t_status            status;
    } t_result;

endpackage

[rtl/rsi_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module rsi_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/rsi_scan.sv]
// Key store, shared key comparator and the sequencer that scans and appends.
module rsi_scan import rsi_pkg::*; #(
    parameter int TABLE_DEPTH = 256
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_start,
    input  t_key    i_key,
    output logic    o_idle,
    output logic    o_res_valid,
    output t_result o_res,
    input  logic    i_res_take
);

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_SCAN   = 4'b0010,
        S_INSERT = 4'b0100,
        S_DONE   = 4'b1000
    } t_state;

    t_state          r_state, n_state;
    logic [CW-1:0]   r_count, n_count;
    t_key            r_key, n_key;
    logic [AW-1:0]   r_addr, n_addr;
    t_result         r_res, n_res;

    logic [AW-1:0]   rd_addr;
    t_key            rd_data;
    logic            hit;
    logic            last;
    logic            full;
    logic            wr_en;

    rsi_ram #(
        .WIDTH (KEY_W),
        .DEPTH (TABLE_DEPTH)
    ) u_key_store (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (r_count[AW-1:0]),
        .i_wdata (r_key),
        .i_raddr (rd_addr),
        .o_rdata (rd_data)
    );

    assign hit     = (rd_data == r_key);
    assign last    = ((CW'(r_addr) + CW'(1)) == r_count);
    assign full    = (r_count == CW'(TABLE_DEPTH));
    assign wr_en   = (r_state == S_INSERT);
    assign rd_addr = (r_state == S_IDLE) ? '0 : AW'(r_addr + AW'(1));

    always_comb begin
        n_state = r_state;
        n_count = r_count;
        n_key   = r_key;
        n_addr  = r_addr;
        n_res   = r_res;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_key   = i_key;
                    n_addr  = '0;
                    n_state = (r_count == '0) ? S_INSERT : S_SCAN;
                end
            end
            S_SCAN: begin
                if (hit) begin
                    n_res.set_index = INDEX_W'(r_addr);
                    n_res.status    = ST_FOUND;
                    n_state         = S_DONE;
                end else if (last) begin
                    if (full) begin
                        n_res.set_index = '0;
                        n_res.status    = ST_FULL;
                        n_state         = S_DONE;
                    end else begin
                        n_state = S_INSERT;
                    end
                end else begin
                    n_addr = AW'(r_addr + AW'(1));
                end
            end
            S_INSERT: begin
                n_res.set_index = INDEX_W'(r_count);
                n_res.status    = ST_NEW;
                n_count         = CW'(r_count + CW'(1));
                n_state         = S_DONE;
            end
            S_DONE: begin
                if (i_res_take) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_key  <= n_key;
        r_addr <= n_addr;
        r_res  <= n_res;
    end

    assign o_idle      = (r_state == S_IDLE);
    assign o_res_valid = (r_state == S_DONE);
    assign o_res       = r_res;

endmodule

[rtl/render_state_set_interner.sv]
// Render state set interner top level: packs six state identifiers into a key and
// returns its dense index. Stored keys are scanned from index 0, the key store being
// read and compared one entry per cycle; a new key is appended at index count, the
// number of keys held, and a miss on a full table is answered as full. The next item
// is accepted once the scan has handed its result to the output register.
`include "render_state_set_interner_defines.svh"

module render_state_set_interner import rsi_pkg::*; #(
    parameter int TABLE_DEPTH = 256
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    output logic                      o_in_ready,
    input  logic [ALPHA_BITS-1:0]     i_alpha_id,
    input  logic [CULL_BITS-1:0]      i_cull_id,
    input  logic [FOG_BITS-1:0]       i_fog_id,
    input  logic [MATERIAL_BITS-1:0]  i_material_id,
    input  logic [WIREFRAME_BITS-1:0] i_wireframe_id,
    input  logic [ZBUFFER_BITS-1:0]   i_depth_buffer_id,
    output logic                      o_out_valid,
    input  logic                      i_out_ready,
    output logic [INDEX_W-1:0]        o_set_index,
    output logic [1:0]                o_status
);

    t_key    key;
    logic    idle;
    logic    res_valid;
    logic    res_take;
    t_result res;
    logic    r_out_valid;
    t_result r_out;

    assign key = {i_depth_buffer_id, i_wireframe_id, i_material_id,
                  i_fog_id, i_cull_id, i_alpha_id};

    rsi_scan #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_scan (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (i_in_valid),
        .i_key       (key),
        .o_idle      (idle),
        .o_res_valid (res_valid),
        .o_res       (res),
        .i_res_take  (res_take)
    );

    assign res_take = res_valid && (!r_out_valid || i_out_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_take) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_take) begin
            r_out <= res;
        end
    end

    assign o_in_ready  = idle;
    assign o_out_valid = r_out_valid;
    assign o_set_index = r_out.set_index;
    assign o_status    = r_out.status;

    `RSI_ASSERT_NEXT(a_busy_after_accept, i_in_valid && o_in_ready, !o_in_ready, "block ready right after accepting an item")
    `RSI_ASSERT(a_full_index_zero, (o_out_valid && o_status == ST_FULL) |-> (o_set_index == '0), "full result with nonzero index")
    `RSI_ASSERT(a_no_overwrite, !(res_take && o_out_valid && !i_out_ready), "result loaded over a waiting result")

endmodule

[verif/testbench.sv]
// Self-checking testbench of the render state set interner: drives keys, predicts indexes.
module testbench;
    import rsi_pkg::*;

    localparam int TABLE_DEPTH = 256;
    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int CULL_LSB      = ALPHA_BITS;
    localparam int FOG_LSB       = CULL_LSB + CULL_BITS;
    localparam int MATERIAL_LSB  = FOG_LSB + FOG_BITS;
    localparam int WIREFRAME_LSB = MATERIAL_LSB + MATERIAL_BITS;
    localparam int ZBUFFER_LSB   = WIREFRAME_LSB + WIREFRAME_BITS;

    class set_index_scoreboard;
        t_key    stored_keys[TABLE_DEPTH];
        int      key_count;
        t_result expected_results[$];
        int      errors;

        function void note_key(t_key key);
            t_result r;
            bit      hit;
            hit = 1'b0;
            for (int i = 0; i < key_count; i++) begin
                if (stored_keys[i] == key) begin
                    r.set_index = INDEX_W'(i);
                    r.status    = ST_FOUND;
                    hit = 1'b1;
                    break;
                end
            end
            if (!hit) begin
                if (key_count < TABLE_DEPTH) begin
                    stored_keys[key_count] = key;
                    r.set_index = INDEX_W'(key_count);
                    r.status    = ST_NEW;
                    key_count++;
                end else begin
                    r.set_index = '0;
                    r.status    = ST_FULL;
                end
            end
            expected_results.push_back(r);
        endfunction

        function void check_result(logic [INDEX_W-1:0] set_index, logic [1:0] status);
            t_result exp_r;
            if (expected_results.size() == 0) begin
                $error("unexpected item: set_index %0d, status %0d", set_index, status);
                errors++;
                return;
            end
            exp_r = expected_results.pop_front();
            if (set_index !== exp_r.set_index) begin
                $error("set_index: expected %0d, got %0d", exp_r.set_index, set_index);
                errors++;
            end
            if (status !== exp_r.status) begin
                $error("status: expected %0d, got %0d", exp_r.status, status);
                errors++;
            end
        endfunction
    endclass

    logic                      i_clk = 1'b0;
    logic                      i_rst_n = 1'b0;
    logic                      i_in_valid = 1'b0;
    logic                      o_in_ready;
    logic [ALPHA_BITS-1:0]     i_alpha_id = '0;
    logic [CULL_BITS-1:0]      i_cull_id = '0;
    logic [FOG_BITS-1:0]       i_fog_id = '0;
    logic [MATERIAL_BITS-1:0]  i_material_id = '0;
    logic [WIREFRAME_BITS-1:0] i_wireframe_id = '0;
    logic [ZBUFFER_BITS-1:0]   i_depth_buffer_id = '0;
    logic                      o_out_valid;
    logic                      i_out_ready = 1'b0;
    logic [INDEX_W-1:0]        o_set_index;
    logic [1:0]                o_status;

    set_index_scoreboard sb = new();
    bit calm_phase = 1'b0;
    int cycle_count = 0;

    render_state_set_interner #(.TABLE_DEPTH(TABLE_DEPTH)) i_dut (.*);

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("render_state_set_interner regression: fail");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            sb.check_result(o_set_index, o_status);
        end
    end

    function automatic int pick_idle();
        int r;
        r = $urandom_range(0, 99);
        if (calm_phase || r < 50) return 0;
        if (r < 88) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic t_key make_key(logic [31:0] alpha, logic [31:0] cull, logic [31:0] fog,
                                      logic [31:0] material, logic [31:0] wireframe,
                                      logic [31:0] zbuffer);
        return {zbuffer[ZBUFFER_BITS-1:0], wireframe[WIREFRAME_BITS-1:0],
                material[MATERIAL_BITS-1:0], fog[FOG_BITS-1:0], cull[CULL_BITS-1:0],
                alpha[ALPHA_BITS-1:0]};
    endfunction

    // Fields lean toward their extremes so that all-zero and all-one values occur often.
    function automatic logic [31:0] random_field();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) return '0;
        if (r == 1) return '1;
        return $urandom;
    endfunction

    function automatic t_key random_key();
        return make_key(random_field(), random_field(), random_field(), random_field(),
                        random_field(), random_field());
    endfunction

    task automatic send_key(t_key key);
        int gap;
        gap = pick_idle();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid        <= 1'b1;
        i_alpha_id        <= key[CULL_LSB-1:0];
        i_cull_id         <= key[FOG_LSB-1:CULL_LSB];
        i_fog_id          <= key[MATERIAL_LSB-1:FOG_LSB];
        i_material_id     <= key[WIREFRAME_LSB-1:MATERIAL_LSB];
        i_wireframe_id    <= key[ZBUFFER_LSB-1:WIREFRAME_LSB];
        i_depth_buffer_id <= key[KEY_W-1:ZBUFFER_LSB];
        do @(posedge i_clk); while (!o_in_ready);
        sb.note_key(key);
    endtask

    initial begin
        int stall;
        forever begin
            stall = pick_idle();
            if (stall > 0) begin
                i_out_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
            repeat ($urandom_range(1, 20)) @(posedge i_clk);
        end
    end

    initial begin
        t_key key_pool[$];
        t_key k;
        int   pick;

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        key_pool.push_back(make_key(0, 0, 0, 0, 0, 0));
        key_pool.push_back(make_key('1, '1, '1, '1, '1, '1));
        key_pool.push_back(make_key(0, 0, 0, 0, 0, 0));
        key_pool.push_back(make_key('1, 0, 0, 0, 0, 0));
        key_pool.push_back(make_key(0, '1, 0, 0, 0, 0));
        key_pool.push_back(make_key(0, 0, '1, 0, 0, 0));
        key_pool.push_back(make_key(0, 0, 0, '1, 0, 0));
        key_pool.push_back(make_key(0, 0, 0, 0, '1, 0));
        key_pool.push_back(make_key(0, 0, 0, 0, 0, '1));
        key_pool.push_back({KEY_W/2{2'b01}});
        key_pool.push_back({KEY_W/2{2'b10}});
        key_pool.push_back(make_key('1, '1, '1, '1, '1, '1));
        key_pool.push_back(make_key(0, 0, 0, '1, 0, 0));
        key_pool.push_back(make_key(1, 0, 0, 0, 0, 0));
        key_pool.push_back(make_key(0, 0, 0, 0, 0, 32'h200));
        foreach (key_pool[i]) send_key(key_pool[i]);

        // The table fills partway through, after which both hits and misses on a full
        // table are exercised.
        for (int n = 0; n < 750; n++) begin
            calm_phase = (n >= 200 && n < 260) || (n >= 600 && n < 640);
            pick = $urandom_range(0, 99);
            if (pick < 50) begin
                k = random_key();
            end else if (pick < 62) begin
                k = key_pool[$urandom_range(0, key_pool.size() - 1)];
                k[$urandom_range(0, KEY_W - 1)] ^= 1'b1;
            end else begin
                k = key_pool[$urandom_range(0, key_pool.size() - 1)];
            end
            send_key(k);
            key_pool.push_back(k);
        end
        i_in_valid <= 1'b0;
        calm_phase = 1'b0;

        while (sb.expected_results.size() != 0) @(posedge i_clk);
        repeat (TABLE_DEPTH + 16) @(posedge i_clk);
        if (sb.errors == 0 && sb.expected_results.size() == 0) begin
            $display("render_state_set_interner regression: pass");
        end else begin
            $display("render_state_set_interner regression: fail");
        end
        $finish;
    end
endmodule

[filelist.f]
+incdir+rtl
rtl/rsi_pkg.sv
rtl/rsi_ram.sv
rtl/rsi_scan.sv
rtl/render_state_set_interner.sv
verif/testbench.sv
